// File: hdl/poi_pkg.sv
// Shared types, constants and tables for the planar odometry integrator.
// No dependencies; every other file imports this package.
package poi_pkg;

    localparam int CORDIC_STEPS = 18;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;
    localparam logic signed [33:0] ANGLE_SCALE     = 34'sd5599767;

    // Distance is |vel * us| plus half of 15625, times the reciprocal of 15625
    // scaled by 2^47, shifted down by 47. The reciprocal is split at bit 17 so
    // that each half fits the shared multiplier; the result is exact for every
    // numerator below 2^35.
    localparam logic [34:0]        DIST_RND = 35'd7812;
    localparam logic signed [33:0] RECIP_LO = 34'sd62487;
    localparam logic signed [33:0] RECIP_HI = 34'sd68719;

    localparam logic [1:0] CASE_STRAIGHT = 2'd0;
    localparam logic [1:0] CASE_ROTATE   = 2'd1;
    localparam logic [1:0] CASE_ARC      = 2'd2;

    localparam logic [1:0] REG_STILL_YAW  = 2'd0;
    localparam logic [1:0] REG_SMALL_FWD  = 2'd1;
    localparam logic [1:0] REG_SMALL_LEFT = 2'd2;

    localparam logic [14:0] RST_STILL_YAW  = 15'd2;
    localparam logic [15:0] RST_SMALL_FWD  = 16'd655;
    localparam logic [15:0] RST_SMALL_LEFT = 16'd1311;

    typedef struct packed {
        logic [15:0] vel_forward;
        logic [15:0] vel_left;
        logic [15:0] yaw_rate;
        logic [19:0] elapsed_us;
        logic        straight;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic        done;
        logic [33:0] sin_val;
        logic [33:0] cos_val;
    } t_cordic_rsp;

    // Arctangent of 2^-i in 32-bit turn units.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/poi_front.sv
// Front end: accepts input items and marks the straight-motion case.
// Depends on poi_pkg.
module poi_front import poi_pkg::*; (
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_vel_forward,
    input  logic [15:0] i_vel_left,
    input  logic [15:0] i_yaw_rate,
    input  logic [19:0] i_elapsed_us,
    input  logic [14:0] i_still_thr,
    input  logic        i_q_full,
    output logic        o_q_wr,
    output t_item       o_q_item
);
    logic [15:0] wmag;

    always_comb begin
        wmag = i_yaw_rate[15] ? (16'd0 - i_yaw_rate) : i_yaw_rate;
        o_q_item.vel_forward = i_vel_forward;
        o_q_item.vel_left    = i_vel_left;
        o_q_item.yaw_rate    = i_yaw_rate;
        o_q_item.elapsed_us  = i_elapsed_us;
        o_q_item.straight    = (i_yaw_rate == 16'd0) || (wmag < {1'b0, i_still_thr});
    end

    assign o_full = i_q_full;
    assign o_q_wr = i_push && !i_q_full;

endmodule

// File: hdl/poi_fifo.sv
// Short item queue between the front end and the back end.
// Depends on poi_pkg.
module poi_fifo import poi_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_rdata,
    output logic  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= nxt(r_wptr);
            end
            if (i_rd) begin
                r_rptr <= nxt(r_rptr);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CW'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// File: hdl/poi_cordic.sv
// Iterative rotation-mode CORDIC giving sine and cosine of a 32-bit turn angle.
// Depends on poi_pkg.
module poi_cordic import poi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);
    logic               r_busy, r_done, r_flip;
    logic [4:0]         r_cnt;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] xs, ys, at;
    logic [31:0]        adj;
    logic               flip;

    always_comb begin
        flip = (i_req.angle[31:30] == 2'b01) || (i_req.angle[31:30] == 2'b10);
        adj  = flip ? (i_req.angle - 32'h8000_0000) : i_req.angle;
        xs   = r_y >>> r_cnt;
        ys   = r_x >>> r_cnt;
        at   = signed'({2'b00, atan_turn(r_cnt)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_flip <= flip;
            r_x    <= CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= signed'({{2{adj[31]}}, adj});
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - xs;
                r_y <= r_y + ys;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + xs;
                r_y <= r_y - ys;
                r_z <= r_z + at;
            end
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_comb begin
        o_rsp.done    = r_done;
        o_rsp.sin_val = r_flip ? (34'd0 - r_y) : r_y;
        o_rsp.cos_val = r_flip ? (34'd0 - r_x) : r_x;
    end

endmodule

// File: hdl/poi_back.sv
// Back end: sequencer with a shared multiplier and a bit-serial divider that
// forms the motion increment, rotates it and updates the pose. Uses poi_pkg.
module poi_back import poi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_q_rd,
    input  logic [15:0] i_fwd_thr,
    input  logic [15:0] i_left_thr,
    output t_cordic_req o_cordic_req,
    input  t_cordic_rsp i_cordic_rsp,
    input  logic        i_pop,
    output logic        o_valid,
    output logic [31:0] o_pose_x,
    output logic [31:0] o_pose_y,
    output logic [15:0] o_pose_heading,
    output logic [1:0]  o_motion_case
);
    localparam logic [4:0] S_IDLE = 5'd0,  S_MF = 5'd1,  S_DF = 5'd2,  S_WF = 5'd3;
    localparam logic [4:0] S_ML   = 5'd4,  S_DL = 5'd5,  S_WL = 5'd6,  S_MW = 5'd7;
    localparam logic [4:0] S_MA   = 5'd8,  S_AN = 5'd9,  S_WC = 5'd10, S_N1 = 5'd11;
    localparam logic [4:0] S_N2   = 5'd12, S_N3 = 5'd13, S_WX = 5'd14, S_N4 = 5'd15;
    localparam logic [4:0] S_N5   = 5'd16, S_N6 = 5'd17, S_WY = 5'd18, S_HS = 5'd19;
    localparam logic [4:0] S_WH   = 5'd20, S_R1 = 5'd21, S_R2 = 5'd22, S_R3 = 5'd23;
    localparam logic [4:0] S_R4   = 5'd24, S_R5 = 5'd25, S_R6 = 5'd26, S_DONE = 5'd27;
    localparam logic [4:0] S_RF   = 5'd28, S_HF = 5'd29, S_RL = 5'd30, S_HL = 5'd31;

    logic [4:0]         r_state, n_state;
    t_item              r_item;
    logic signed [71:0] r_prod, r_acc;
    logic signed [37:0] ma;
    logic signed [33:0] mb;
    logic [31:0]        r_fd, r_ld, r_dx, r_dy, r_rx, r_ry;
    logic [15:0]        r_dhead;
    logic [1:0]         r_case;
    logic signed [33:0] r_s, r_c;
    logic [31:0]        r_pos_x, r_pos_y;
    logic [15:0]        r_head;
    logic               r_out_valid;
    logic [31:0]        r_out_x, r_out_y;
    logic [15:0]        r_out_head;
    logic [1:0]         r_out_case;

    // Distance registers: rounded magnitude and sign of vel * us.
    logic [34:0]        r_dabs;
    logic               r_sneg;

    // Divider registers.
    logic [51:0]        r_dq;
    logic [29:0]        r_drem;
    logic [28:0]        r_dden;
    logic               r_dneg, r_dbusy, r_ddone;
    logic [5:0]         r_dcnt;

    logic               div_start;
    logic signed [71:0] div_num, nabs;
    logic [28:0]        div_den, wden;
    logic               div_dneg;
    logic [29:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        q32;

    logic signed [71:0] pabs, dist_sum;
    logic [31:0]        dist_q;

    logic signed [33:0] us_s;
    logic [15:0]        wmag;
    logic signed [71:0] ang_sum, rot_sum;
    logic [31:0]        dh_sum, fabs, labs;
    logic               small_move, out_free;

    always_comb begin
        us_s    = signed'({14'd0, r_item.elapsed_us});
        wmag    = r_item.yaw_rate[15] ? (16'd0 - r_item.yaw_rate) : r_item.yaw_rate;
        wden    = {wmag, 13'd0};
        ang_sum = r_prod + 72'sd8388608;
        dh_sum  = ang_sum[55:24] + 32'h0000_8000;
        fabs    = r_fd[31] ? (32'd0 - r_fd) : r_fd;
        labs    = r_ld[31] ? (32'd0 - r_ld) : r_ld;
        small_move = (fabs < {16'd0, i_fwd_thr}) && (labs < {16'd0, i_left_thr});
        out_free   = !r_out_valid || i_pop;
        rot_sum    = (r_state == S_R3) ? (r_acc - r_prod + 72'sd536870912)
                                       : (r_acc + r_prod + 72'sd536870912);
        pabs     = r_prod[71] ? (72'sd0 - r_prod) : r_prod;
        dist_sum = (r_prod <<< 17) + r_acc;
        dist_q   = r_sneg ? (32'd0 - {7'd0, dist_sum[71:47]}) : {7'd0, dist_sum[71:47]};
    end

    // Shared multiplier operand selection.
    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_MF: begin ma = 38'(signed'(r_item.vel_forward)); mb = us_s; end
            S_ML: begin ma = 38'(signed'(r_item.vel_left)); mb = us_s; end
            S_RF, S_RL: begin ma = {3'b000, r_dabs}; mb = RECIP_LO; end
            S_HF, S_HL: begin ma = {3'b000, r_dabs}; mb = RECIP_HI; end
            S_MW: begin ma = 38'(signed'(r_item.yaw_rate)); mb = us_s; end
            S_MA: begin ma = r_prod[37:0]; mb = ANGLE_SCALE; end
            S_N1: begin ma = 38'(signed'(r_item.vel_forward)); mb = r_s; end
            S_N2: begin ma = 38'(signed'(r_item.vel_left)); mb = r_c - ONE_Q30; end
            S_N4: begin ma = 38'(signed'(r_item.vel_forward)); mb = ONE_Q30 - r_c; end
            S_N5: begin ma = 38'(signed'(r_item.vel_left)); mb = r_s; end
            S_R1: begin ma = 38'(signed'(r_dx)); mb = r_c; end
            S_R2: begin ma = 38'(signed'(r_dy)); mb = r_s; end
            S_R4: begin ma = 38'(signed'(r_dx)); mb = r_s; end
            S_R5: begin ma = 38'(signed'(r_dy)); mb = r_c; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // Divider operands: only the two arc divisions by 8192 * yaw use it.
    always_comb begin
        div_start = (r_state == S_N3) || (r_state == S_N6);
        div_num   = r_acc + r_prod;
        div_den   = wden;
        div_dneg  = r_item.yaw_rate[15];
        nabs   = div_num[71] ? (72'sd0 - div_num) : div_num;
        rem_sh = {r_drem[28:0], r_dq[51]};
        rem_ge = rem_sh >= {1'b0, r_dden};
        q32    = r_dneg ? (32'd0 - r_dq[31:0]) : r_dq[31:0];
    end

    always_comb begin
        o_cordic_req.start = (r_state == S_AN && !r_item.straight && !small_move) ||
                             (r_state == S_HS);
        o_cordic_req.angle = (r_state == S_HS) ? {r_head, 16'd0} : ang_sum[55:24];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (!i_q_empty) n_state = S_MF;
            S_MF:   n_state = S_DF;
            S_DF:   n_state = S_RF;
            S_RF:   n_state = S_HF;
            S_HF:   n_state = S_WF;
            S_WF:   n_state = S_ML;
            S_ML:   n_state = S_DL;
            S_DL:   n_state = S_RL;
            S_RL:   n_state = S_HL;
            S_HL:   n_state = S_WL;
            S_WL:   n_state = r_item.straight ? S_HS : S_MW;
            S_MW:   n_state = S_MA;
            S_MA:   n_state = S_AN;
            S_AN:   n_state = small_move ? S_HS : S_WC;
            S_WC:   if (i_cordic_rsp.done) n_state = S_N1;
            S_N1:   n_state = S_N2;
            S_N2:   n_state = S_N3;
            S_N3:   n_state = S_WX;
            S_WX:   if (r_ddone) n_state = S_N4;
            S_N4:   n_state = S_N5;
            S_N5:   n_state = S_N6;
            S_N6:   n_state = S_WY;
            S_WY:   if (r_ddone) n_state = S_HS;
            S_HS:   n_state = S_WH;
            S_WH:   if (i_cordic_rsp.done) n_state = S_R1;
            S_R1:   n_state = S_R2;
            S_R2:   n_state = S_R3;
            S_R3:   n_state = S_R4;
            S_R4:   n_state = S_R5;
            S_R5:   n_state = S_R6;
            S_R6:   n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_q_rd = (r_state == S_IDLE) && !i_q_empty;

    // Control state, divider control, pose and result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dbusy     <= 1'b0;
            r_ddone     <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ddone <= 1'b0;
            if (div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == 6'd0) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_pos_x     <= r_pos_x + r_rx;
                r_pos_y     <= r_pos_y + r_ry;
                r_head      <= r_head + r_dhead;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (o_q_rd) begin
            r_item <= i_q_item;
        end
        if (div_start) begin
            r_dq   <= nabs[51:0] + {24'd0, div_den[28:1]};
            r_drem <= '0;
            r_dden <= div_den;
            r_dneg <= div_num[71] ^ div_dneg;
            r_dcnt <= 6'd51;
        end else if (r_dbusy) begin
            r_drem <= rem_ge ? (rem_sh - {1'b0, r_dden}) : rem_sh;
            r_dq   <= {r_dq[50:0], rem_ge};
            r_dcnt <= r_dcnt - 6'd1;
        end
        case (r_state)
            S_DF, S_DL: begin
                r_dabs <= pabs[34:0] + DIST_RND;
                r_sneg <= r_prod[71];
            end
            S_WF: r_fd <= dist_q;
            S_WL: begin
                r_ld <= dist_q;
                if (r_item.straight) begin
                    r_dx    <= r_fd;
                    r_dy    <= dist_q;
                    r_dhead <= '0;
                    r_case  <= CASE_STRAIGHT;
                end
            end
            S_AN: begin
                r_dhead <= dh_sum[31:16];
                if (small_move) begin
                    r_dx   <= '0;
                    r_dy   <= '0;
                    r_case <= CASE_ROTATE;
                end else begin
                    r_case <= CASE_ARC;
                end
            end
            S_WC, S_WH: begin
                if (i_cordic_rsp.done) begin
                    r_s <= i_cordic_rsp.sin_val;
                    r_c <= i_cordic_rsp.cos_val;
                end
            end
            S_HF, S_HL, S_N2, S_N5, S_R2, S_R5: r_acc <= r_prod;
            S_WX: if (r_ddone) r_dx <= q32;
            S_WY: if (r_ddone) r_dy <= q32;
            S_R3: r_rx <= rot_sum[61:30];
            S_R6: r_ry <= rot_sum[61:30];
            S_DONE: begin
                if (out_free) begin
                    r_out_x    <= r_pos_x + r_rx;
                    r_out_y    <= r_pos_y + r_ry;
                    r_out_head <= r_head + r_dhead;
                    r_out_case <= r_case;
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_head;
    assign o_motion_case  = r_out_case;

endmodule

// File: hdl/planar_odometry_integrator_unit.sv
// Top level of the planar odometry integrator: configuration registers,
// front end, item queue, back-end sequencer and CORDIC. Depends on poi_pkg.
//
//  Channel   Handshake          Payload
//  input     i_push / o_full    i_vel_forward, i_vel_left, i_yaw_rate, i_elapsed_us
//  result    o_empty / i_pop    o_pose_x, o_pose_y, o_pose_heading, o_motion_case
//  config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// Each distance is a reciprocal multiplication split into a low and a high
// half, and each of the two arc divisions runs a 52-step bit-serial divider.
// Reset is synchronous and active low; it clears the pose and loads the
// register reset values. The front end keeps taking items into the queue
// while the back end works or while a finished result waits for its
// transfer; a full queue raises o_full.
module planar_odometry_integrator_unit import poi_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [15:0] i_vel_forward,
    input  logic [15:0] i_vel_left,
    input  logic [15:0] i_yaw_rate,
    input  logic [19:0] i_elapsed_us,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_pose_x,
    output logic [31:0] o_pose_y,
    output logic [15:0] o_pose_heading,
    output logic [1:0]  o_motion_case,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    logic [14:0]  r_still_thr;
    logic [15:0]  r_fwd_thr, r_left_thr;

    logic         q_full, q_empty, q_wr, q_rd;
    t_item        q_wdata, q_rdata;
    t_cordic_req  cordic_req;
    t_cordic_rsp  cordic_rsp;
    logic         out_valid;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_still_thr <= RST_STILL_YAW;
            r_fwd_thr   <= RST_SMALL_FWD;
            r_left_thr  <= RST_SMALL_LEFT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_STILL_YAW:  r_still_thr <= i_cfg_data[14:0];
                REG_SMALL_FWD:  r_fwd_thr   <= i_cfg_data;
                REG_SMALL_LEFT: r_left_thr  <= i_cfg_data;
                default:        r_still_thr <= r_still_thr;
            endcase
        end
    end

    poi_front u_front (
        .i_push        (i_push),
        .o_full        (o_full),
        .i_vel_forward (i_vel_forward),
        .i_vel_left    (i_vel_left),
        .i_yaw_rate    (i_yaw_rate),
        .i_elapsed_us  (i_elapsed_us),
        .i_still_thr   (r_still_thr),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_item      (q_wdata)
    );

    poi_fifo #(.DEPTH(P_QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    poi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_rsp   (cordic_rsp)
    );

    // The back end owns the result register; a result stays until its
    // transfer on the result side completes.
    poi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_item       (q_rdata),
        .o_q_rd         (q_rd),
        .i_fwd_thr      (r_fwd_thr),
        .i_left_thr     (r_left_thr),
        .o_cordic_req   (cordic_req),
        .i_cordic_rsp   (cordic_rsp),
        .i_pop          (i_pop),
        .o_valid        (out_valid),
        .o_pose_x       (o_pose_x),
        .o_pose_y       (o_pose_y),
        .o_pose_heading (o_pose_heading),
        .o_motion_case  (o_motion_case)
    );

    assign o_empty = !out_valid;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for planar_odometry_integrator_unit.
// Predicts each pose update in SystemVerilog and checks every result transfer.
// Depends on poi_pkg and the unit's RTL.
module tb_top;
    import poi_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [15:0] i_vel_forward = '0;
    logic [15:0] i_vel_left = '0;
    logic [15:0] i_yaw_rate = '0;
    logic [19:0] i_elapsed_us = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [31:0] o_pose_x;
    logic [31:0] o_pose_y;
    logic [15:0] o_pose_heading;
    logic [1:0]  o_motion_case;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    planar_odometry_integrator_unit u_dut (.*);

    // The clock runs with a 12 unit period, six high and six low.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] heading;
        logic [1:0]  mcase;
    } t_pose;

    // Predictor state: a private copy of the registers and the pose.
    logic [14:0] cfg_still_yaw;
    logic [15:0] cfg_small_fwd;
    logic [15:0] cfg_small_left;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [15:0] acc_heading;

    t_pose pose_queue[$];
    int    errors = 0;
    int    sent_items = 0;
    int    checked_poses = 0;
    int    case_seen[3] = '{0, 0, 0};
    bit    quiet_mode = 1'b0;

    function automatic longint fshift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Rotation CORDIC on a 32-bit turn angle; the middle quadrants are folded.
    task automatic turn_sin_cos(input logic [31:0] angle, output longint s,
                                output longint c);
        logic [1:0] quad;
        bit         flip;
        longint     x;
        longint     y;
        longint     z;
        longint     xs;
        longint     ys;
        quad = angle[31:30];
        flip = (quad == 2'd1) || (quad == 2'd2);
        if (flip) angle = angle - 32'h80000000;
        x = 652032874;
        y = 0;
        z = longint'(signed'(angle));
        for (int i = 0; i < 18; i++) begin
            xs = fshift(y, i);
            ys = fshift(x, i);
            if (z >= 0) begin
                x -= xs; y += ys; z -= longint'(atan_turn(i[4:0]));
            end else begin
                x += xs; y -= ys; z += longint'(atan_turn(i[4:0]));
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    task automatic predict_pose(input logic [15:0] vf_b, input logic [15:0] vl_b,
                                input logic [15:0] w_b, input logic [19:0] us_b);
        longint      vf;
        longint      vl;
        longint      w;
        longint      us;
        longint      wmag;
        longint      dx;
        longint      dy;
        longint      fd;
        longint      ld;
        longint      s;
        longint      c;
        longint      hs;
        longint      hc;
        longint      rx;
        longint      ry;
        logic [63:0] prod;
        logic [31:0] ang;
        logic [15:0] dhead;
        logic [1:0]  mc;
        t_pose       p;
        vf = longint'(signed'(vf_b));
        vl = longint'(signed'(vl_b));
        w = longint'(signed'(w_b));
        us = longint'(us_b);
        wmag = (w < 0) ? -w : w;
        dx = 0;
        dy = 0;
        dhead = '0;
        if (w == 0 || wmag < longint'(cfg_still_yaw)) begin
            mc = CASE_STRAIGHT;
            dx = round_div(vf * us, 15625);
            dy = round_div(vl * us, 15625);
        end else begin
            fd = round_div(vf * us, 15625);
            ld = round_div(vl * us, 15625);
            prod = 64'(w * us * 5599767) + 64'h800000;
            ang = prod[55:24];
            dhead = 16'((ang + 32'h8000) >> 16);
            if (((fd < 0) ? -fd : fd) < longint'(cfg_small_fwd) &&
                ((ld < 0) ? -ld : ld) < longint'(cfg_small_left)) begin
                mc = CASE_ROTATE;
            end else begin
                mc = CASE_ARC;
                turn_sin_cos(ang, s, c);
                // Large arcs wrap to a signed 32-bit increment before rotation.
                dx = longint'(signed'(32'(round_div(vf * s + vl * (c - 64'sd1073741824),
                                                   8192 * w))));
                dy = longint'(signed'(32'(round_div(vf * (64'sd1073741824 - c) + vl * s,
                                                   8192 * w))));
            end
        end
        turn_sin_cos({acc_heading, 16'h0}, hs, hc);
        rx = fshift(dx * hc - dy * hs + (64'sd1 << 29), 30);
        ry = fshift(dx * hs + dy * hc + (64'sd1 << 29), 30);
        acc_x = acc_x + 32'(rx);
        acc_y = acc_y + 32'(ry);
        acc_heading = acc_heading + dhead;
        p.x = acc_x;
        p.y = acc_y;
        p.heading = acc_heading;
        p.mcase = mc;
        pose_queue.push_back(p);
    endtask

    // Idle with a chance of roughly 19 in a hundred unless in a quiet stretch.
    function automatic bit take_gap();
        return !quiet_mode && ($urandom_range(99) < 19);
    endfunction

    // Sends one item; the prediction is made at the edge of its transfer.
    // Push stays high after the transfer until the next item or idle cycle.
    task automatic send_item(input logic [15:0] vf, input logic [15:0] vl,
                             input logic [15:0] w, input logic [19:0] us);
        while (take_gap()) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_vel_forward <= vf;
        i_vel_left <= vl;
        i_yaw_rate <= w;
        i_elapsed_us <= us;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_pose(vf, vl, w, us);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Result side: random pop with a check at every accepted transfer.
    always @(negedge i_clk) begin
        i_pop <= !take_gap();
    end

    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pose_queue.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h h=%h case=%0d", $time,
                         o_pose_x, o_pose_y, o_pose_heading, o_motion_case);
                errors++;
            end else begin
                e = pose_queue.pop_front();
                checked_poses++;
                if (e.mcase < 3) case_seen[e.mcase]++;
                if (o_pose_x !== e.x) begin
                    $display("%0t: pose_x expected %h actual %h", $time, e.x, o_pose_x);
                    errors++;
                end
                if (o_pose_y !== e.y) begin
                    $display("%0t: pose_y expected %h actual %h", $time, e.y, o_pose_y);
                    errors++;
                end
                if (o_pose_heading !== e.heading) begin
                    $display("%0t: pose_heading expected %h actual %h", $time,
                             e.heading, o_pose_heading);
                    errors++;
                end
                if (o_motion_case !== e.mcase) begin
                    $display("%0t: motion_case expected %0d actual %0d", $time,
                             e.mcase, o_motion_case);
                    errors++;
                end
            end
        end
    end

    // Waits until every predicted pose has arrived, then lets the block settle.
    task automatic drain_poses();
        i_push <= 1'b0;
        while (pose_queue.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        drain_poses();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_STILL_YAW) cfg_still_yaw = data[14:0];
        else if (idx == REG_SMALL_FWD) cfg_small_fwd = data;
        else if (idx == REG_SMALL_LEFT) cfg_small_left = data;
    endtask

    task automatic test_directed_extremes();
        send_item(16'h0000, 16'h0000, 16'h0000, 20'h00000);
        send_item(16'h7FFF, 16'h8000, 16'h0000, 20'hFFFFF);
        send_item(16'h8000, 16'h7FFF, 16'h0001, 20'hFFFFF);
        send_item(16'h0000, 16'h0000, 16'h7FFF, 20'd1000);
        send_item(16'h0010, 16'h0000, 16'h8000, 20'd100);
        send_item(16'h0400, 16'h0200, 16'h0800, 20'd20000);
        send_item(16'h7FFF, 16'h7FFF, 16'h8000, 20'hFFFFF);
        send_item(16'h8000, 16'h8000, 16'h7FFF, 20'hFFFFF);
        send_item(16'h8000, 16'h8000, 16'h0002, 20'hFFFFF);
        send_item(16'h7FFF, 16'h0000, 16'h0000, 20'hFFFFF);
        send_item(16'hFFFF, 16'h0001, 16'hFFFF, 20'd1);
        send_item(16'h0400, 16'hFC00, 16'hF800, 20'd50000);
    endtask

    task automatic test_zero_threshold();
        // A zero threshold still sends a zero yaw rate down the straight path.
        write_reg(REG_STILL_YAW, 16'h0000);
        send_item(16'h0400, 16'h0400, 16'h0000, 20'd5000);
        send_item(16'h0400, 16'h0400, 16'h0001, 20'd5000);
        write_reg(REG_STILL_YAW, 16'hFFFF);
        send_item(16'h0400, 16'h0100, 16'h7FFF, 20'd5000);
        send_item(16'h0400, 16'h0100, 16'h8000, 20'd5000);
        write_reg(REG_SMALL_FWD, 16'hFFFF);
        write_reg(REG_SMALL_LEFT, 16'hFFFF);
        write_reg(REG_STILL_YAW, 16'd2);
        send_item(16'h0100, 16'h0100, 16'h0400, 20'd10000);
        write_reg(REG_SMALL_FWD, 16'h0000);
        write_reg(REG_SMALL_LEFT, 16'h0000);
        send_item(16'h0000, 16'h0000, 16'h0400, 20'd10000);
        write_reg(3, 16'h1234);
        send_item(16'h0000, 16'h0000, 16'h0400, 20'd10000);
    endtask

    task automatic send_random(input int count);
        logic [15:0] w;
        logic [19:0] us;
        for (int n = 0; n < count; n++) begin
            quiet_mode = (n % 300) < 60;
            case ($urandom_range(5))
                0: w = 16'($urandom);
                1: w = 16'($urandom_range(8));
                2: w = -16'($urandom_range(8));
                default: w = 16'(int'($urandom_range(8000)) - 4000);
            endcase
            us = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(60000));
            send_item(16'($urandom), 16'($urandom), w, us);
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_random_settings();
        write_reg(REG_STILL_YAW, RST_STILL_YAW);
        write_reg(REG_SMALL_FWD, RST_SMALL_FWD);
        write_reg(REG_SMALL_LEFT, RST_SMALL_LEFT);
        send_random(400);
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_STILL_YAW, 16'($urandom_range(20)));
            write_reg(REG_SMALL_FWD, 16'($urandom));
            write_reg(REG_SMALL_LEFT, 16'($urandom));
            send_random(150);
        end
        write_reg(REG_STILL_YAW, 16'h7FFF);
        send_random(30);
    endtask

    initial begin
        cfg_still_yaw = RST_STILL_YAW;
        cfg_small_fwd = RST_SMALL_FWD;
        cfg_small_left = RST_SMALL_LEFT;
        acc_x = '0;
        acc_y = '0;
        acc_heading = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_extremes();
        test_zero_threshold();
        test_random_settings();
        drain_poses();
        $display("Sent %0d items and checked %0d poses: %0d straight, %0d rotation, %0d arc.",
                 sent_items, checked_poses, case_seen[0], case_seen[1], case_seen[2]);
        if (errors == 0 && pose_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // About 1050 items, plus the settling time after each register write and the
    // idle cycles on both sides, fit well below this.
    initial begin
        #15000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
